// ===== hw/rtl/rwhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhm_pkg
// shared codes, widths and reset values of the random walk height map
// ----------------------------------------------------------------------------
package rwhm_pkg;

    localparam int KIND_W   = 2;
    localparam int WALKER_W = 4;
    localparam int COORD_W  = 8;
    localparam int RAND_W   = 15;
    localparam int HEIGHT_W = 8;
    localparam int LIMIT_W  = 16;
    localparam int ACTIVE_W = 5;
    localparam int CFG_IDX_W = 2;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam kind_t KIND_PLACE = 2'd0;
    localparam kind_t KIND_STEP  = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;
    localparam kind_t KIND_CLEAR = 2'd3;

    localparam cfg_idx_t CFG_UP_LIMIT    = 2'd0;
    localparam cfg_idx_t CFG_DOWN_LIMIT  = 2'd1;
    localparam cfg_idx_t CFG_RIGHT_LIMIT = 2'd2;
    localparam cfg_idx_t CFG_ACTIVE      = 2'd3;

    localparam logic [LIMIT_W-1:0]  UP_LIMIT_RST    = 16'd8191;
    localparam logic [LIMIT_W-1:0]  DOWN_LIMIT_RST  = 16'd16383;
    localparam logic [LIMIT_W-1:0]  RIGHT_LIMIT_RST = 16'd24573;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST      = 5'd1;

endpackage

// ===== hw/rtl/rwhm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhm_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rwhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/random_walk_height_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_walk_height_map
// toroidal height map of 8-bit counts driven by place, step, read and clear items
// ----------------------------------------------------------------------------
// Items enter on the s_ channel (kind in s_tuser), results leave on the m_
// channel, one result per item. Limits and the active walker count are set
// through the cfg_ write channel, which is always ready.
// The map lives in one synchronous ram and the walker positions in another.
// An item is accepted in idle; the next cycle reads the walker position and
// issues the map read (or the clear write); the cycle after that forms the
// new count, writes it back for a step and loads the output register. A new
// item is accepted only once the previous one has passed the walker read and
// the map read-modify-write. After reset the map is zeroed by a sweep over
// all MAP_ROWS * MAP_COLS entries (65536 by default) with s_tready low;
// walker positions reset to zero through per-walker valid bits. While the
// receiver stalls, the result holds in the output register; one further
// item is accepted and then waits for the output register before its
// result is written.
// ----------------------------------------------------------------------------
module random_walk_height_map #(
    parameter int MAP_ROWS     = 256,
    parameter int MAP_COLS     = 256,
    parameter int WALKER_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // walker[3:0], row[11:4], col[19:12], random[34:20]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_row[7:0], out_col[15:8], height[23:16]
    output logic        m_tuser,   // ignored
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int RW        = $clog2(MAP_ROWS);
    localparam int CW        = $clog2(MAP_COLS);
    localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int WW        = (WALKER_COUNT > 1) ? $clog2(WALKER_COUNT) : 1;
    localparam int HW        = rwhm_pkg::HEIGHT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_MAP   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [AW-1:0] clr_addr_reg;

    logic [rwhm_pkg::LIMIT_W-1:0]  up_limit_reg, down_limit_reg, right_limit_reg;
    logic [rwhm_pkg::ACTIVE_W-1:0] active_reg;

    rwhm_pkg::kind_t             item_kind_reg;
    logic [rwhm_pkg::WALKER_W-1:0] item_walker_reg;
    logic [RW-1:0]               item_row_reg;
    logic [CW-1:0]               item_col_reg;
    logic [rwhm_pkg::RAND_W-1:0] item_rand_reg;

    logic [RW-1:0] res_row_reg;
    logic [CW-1:0] res_col_reg;
    logic [AW-1:0] res_addr_reg;
    logic          res_ign_reg, res_inc_reg, res_zero_reg;

    logic          m_tvalid_reg;
    logic [23:0]   m_tdata_reg;
    logic          m_tuser_reg;

    logic [WALKER_COUNT-1:0] walk_valid_reg;

    logic [RW-1:0] row_mod_tab [256];
    logic [CW-1:0] col_mod_tab [256];

    logic accept, out_free;

    // walker ram
    logic             walk_we, walk_re;
    logic [WW-1:0]    walk_waddr, walk_raddr, item_widx;
    logic [RW+CW-1:0] walk_wdata, walk_rdata;

    // map ram
    logic             map_we, map_re;
    logic [AW-1:0]    map_waddr, map_raddr;
    logic [HW-1:0]    map_wdata, map_rdata;

    // walk stage
    logic          w_in_range, w_active;
    logic [RW-1:0] wr, new_r;
    logic [CW-1:0] wc, new_c;
    logic [RW-1:0] s_row;
    logic [CW-1:0] s_col;
    logic [HW-1:0] height;

    for (genvar gi = 0; gi < 256; gi++) begin : g_mod
        assign row_mod_tab[gi] = RW'(gi % MAP_ROWS);
        assign col_mod_tab[gi] = CW'(gi % MAP_COLS);
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign s_row     = row_mod_tab[s_tdata[11:4]];
    assign s_col     = col_mod_tab[s_tdata[19:12]];
    assign item_widx = WW'(item_walker_reg);

    assign w_in_range = (32'(item_walker_reg) < WALKER_COUNT);
    assign w_active   = ({1'b0, item_walker_reg} < active_reg);

    assign wr = walk_valid_reg[item_widx] ? walk_rdata[RW+CW-1:CW] : '0;
    assign wc = walk_valid_reg[item_widx] ? walk_rdata[CW-1:0] : '0;

    // direction bands, tested in the order up, down, right
    always_comb begin
        new_r = wr;
        new_c = wc;
        if ({1'b0, item_rand_reg} < up_limit_reg) begin
            new_r = (wr == RW'(MAP_ROWS - 1)) ? '0 : wr + 1'b1;
        end else if ({1'b0, item_rand_reg} < down_limit_reg) begin
            new_r = (wr == '0) ? RW'(MAP_ROWS - 1) : wr - 1'b1;
        end else if ({1'b0, item_rand_reg} < right_limit_reg) begin
            new_c = (wc == CW'(MAP_COLS - 1)) ? '0 : wc + 1'b1;
        end else begin
            new_c = (wc == '0) ? CW'(MAP_COLS - 1) : wc - 1'b1;
        end
    end

    assign height = res_zero_reg ? '0 : HW'(map_rdata + HW'(res_inc_reg));

    assign walk_re    = accept;
    assign walk_raddr = WW'(s_tdata[3:0]);
    assign map_re     = (state_reg == S_WALK);

    always_comb begin
        state_next = state_reg;
        walk_we    = 1'b0;
        walk_waddr = item_widx;
        walk_wdata = {item_row_reg, item_col_reg};
        map_we     = 1'b0;
        map_waddr  = clr_addr_reg;
        map_wdata  = '0;
        map_raddr  = AW'(AW'(item_row_reg) * MAP_COLS + AW'(item_col_reg));
        case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1;
                if (clr_addr_reg == AW'(MAP_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                state_next = S_MAP;
                case (item_kind_reg)
                    rwhm_pkg::KIND_PLACE: begin
                        walk_we = w_in_range;
                    end
                    rwhm_pkg::KIND_STEP: begin
                        map_raddr = w_active
                            ? AW'(AW'(new_r) * MAP_COLS + AW'(new_c))
                            : AW'(AW'(wr) * MAP_COLS + AW'(wc));
                        walk_we    = w_in_range && w_active;
                        walk_wdata = {new_r, new_c};
                    end
                    rwhm_pkg::KIND_CLEAR: begin
                        map_we    = 1'b1;
                        map_waddr = map_raddr;
                    end
                    default: begin
                    end
                endcase
            end
            S_MAP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    map_we     = res_inc_reg;
                    map_waddr  = res_addr_reg;
                    map_wdata  = height;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            up_limit_reg    <= rwhm_pkg::UP_LIMIT_RST;
            down_limit_reg  <= rwhm_pkg::DOWN_LIMIT_RST;
            right_limit_reg <= rwhm_pkg::RIGHT_LIMIT_RST;
            active_reg      <= rwhm_pkg::ACTIVE_RST;
            walk_valid_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rwhm_pkg::CFG_UP_LIMIT:    up_limit_reg    <= cfg_data;
                    rwhm_pkg::CFG_DOWN_LIMIT:  down_limit_reg  <= cfg_data;
                    rwhm_pkg::CFG_RIGHT_LIMIT: right_limit_reg <= cfg_data;
                    rwhm_pkg::CFG_ACTIVE:      active_reg      <= cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            if (walk_we) begin
                walk_valid_reg[walk_waddr] <= 1'b1;
            end
            if (state_reg == S_MAP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_kind_reg   <= s_tuser;
            item_walker_reg <= s_tdata[3:0];
            item_row_reg    <= s_row;
            item_col_reg    <= s_col;
            item_rand_reg   <= s_tdata[34:20];
        end
        if (state_reg == S_WALK) begin
            res_row_reg  <= item_row_reg;
            res_col_reg  <= item_col_reg;
            res_addr_reg <= map_raddr;
            res_ign_reg  <= 1'b0;
            res_inc_reg  <= 1'b0;
            res_zero_reg <= (item_kind_reg == rwhm_pkg::KIND_CLEAR);
            if (item_kind_reg == rwhm_pkg::KIND_STEP) begin
                res_row_reg <= w_active ? new_r : wr;
                res_col_reg <= w_active ? new_c : wc;
                res_ign_reg <= !w_active;
                res_inc_reg <= w_active && w_in_range;
            end
            if ((item_kind_reg == rwhm_pkg::KIND_PLACE ||
                 item_kind_reg == rwhm_pkg::KIND_STEP) && !w_in_range) begin
                res_row_reg  <= '0;
                res_col_reg  <= '0;
                res_ign_reg  <= 1'b1;
                res_inc_reg  <= 1'b0;
                res_zero_reg <= 1'b1;
            end
        end
        if (state_reg == S_MAP && out_free) begin
            m_tdata_reg <= {height, 8'(res_col_reg), 8'(res_row_reg)};
            m_tuser_reg <= res_ign_reg;
        end
    end

    rwhm_ram #(
        .WIDTH (RW + CW),
        .DEPTH (WALKER_COUNT)
    ) u_walk_ram (
        .aclk  (aclk),
        .we    (walk_we),
        .waddr (walk_waddr),
        .wdata (walk_wdata),
        .re    (walk_re),
        .raddr (walk_raddr),
        .rdata (walk_rdata)
    );

    rwhm_ram #(
        .WIDTH (HW),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

`ifndef SYNTH
    a_accept_to_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_WALK)
        else $error("accepted item did not enter walk stage");

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAP && out_free) |=> m_tvalid_reg)
        else $error("finished item produced no result");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !m_tvalid_reg)
        else $error("result during map clearing pass");

    a_walker_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_we |-> (32'(walk_waddr) < WALKER_COUNT && state_reg == S_WALK))
        else $error("walker store written out of range");
`endif

endmodule
